FILE: rtl/cfr_pkg.sv
// ============================================================================
// cfr_pkg: shared constants and types for the celestial frame rotation block
// Angle, fixed-point and pipeline constants, CORDIC and rotation tables.
// ============================================================================
`default_nettype none

package cfr_pkg;

  localparam int ANGLE_W   = 32;            // binary angle, full turn = 2^32
  localparam int Q_W       = 32;            // Q30 vector components
  localparam int STEPS     = 30;            // CORDIC iterations
  localparam int TRIG_W    = 33;            // rotation CORDIC datapath
  localparam int VEC_W     = 36;            // vectoring CORDIC datapath
  localparam int VIN_W     = 33;            // vectoring CORDIC operands
  localparam int SQ_W      = 64;            // radius squared
  localparam int SQRT_STEPS = SQ_W / 2;

  localparam int TRIG_LAT  = STEPS + 2;     // fold, iterations, sign fix
  localparam int VEC_LAT   = STEPS + 1;     // fold, iterations
  localparam int MID_LAT   = 6;             // products through radius sum
  localparam int NST       = TRIG_LAT + MID_LAT + SQRT_STEPS + VEC_LAT + 1;

  localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [Q_W-1:0]    QUARTER  = 32'sd1073741824;
  localparam logic [ANGLE_W-1:0]       HALF_TURN = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0]       QTR_TURN  = 32'h4000_0000;

  // register index on the APB port
  localparam logic REG_DIRECTION = 1'b0;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0
  };

  // equatorial to galactic, Q30
  localparam logic signed [31:0] ROT_Q30 [3][3] = '{
    '{-32'sd58922162,  -32'sd937845953, -32'sd519513860},
    '{ 32'sd530545986, -32'sd477632135,  32'sd802066086},
    '{-32'sd931649418, -32'sd212682900,  32'sd489608873}
  };

  typedef struct packed {
    logic rz;      // planar radius is zero
    logic wneg;    // z negative
    logic wzero;   // z is zero
  } cfr_flags_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        lon;
    logic signed [ANGLE_W-1:0] lat;
    logic                      last;
  } cfr_res_t;

  function automatic logic [31:0] atan_step(input int i);
    logic [31:0] v;
    v = '0;
    if (i < 32) v = ATAN_TAB[i];
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cfr_in_if.sv
// ============================================================================
// cfr_in_if: input item channel
// Valid/ready handshake carrying one sky position per item.
// ============================================================================
`default_nettype none

interface cfr_in_if;
  logic        valid;
  logic        ready;
  logic signed [cfr_pkg::ANGLE_W-1:0] lon_angle;
  logic signed [cfr_pkg::ANGLE_W-1:0] lat_angle;
  logic        last_sample;

  modport source (output valid, lon_angle, lat_angle, last_sample, input ready);
  modport sink   (input valid, lon_angle, lat_angle, last_sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/cfr_out_if.sv
// ============================================================================
// cfr_out_if: result item channel
// Valid/ready handshake carrying one rotated sky position per item.
// ============================================================================
`default_nettype none

interface cfr_out_if;
  logic        valid;
  logic        ready;
  logic [cfr_pkg::ANGLE_W-1:0]        out_lon;
  logic signed [cfr_pkg::ANGLE_W-1:0] out_lat;
  logic        last_out;

  modport source (output valid, out_lon, out_lat, last_out, input ready);
  modport sink   (input valid, out_lon, out_lat, last_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/celestial_frame_rotation_top.sv
// ============================================================================
// celestial_frame_rotation_top: equatorial <-> galactic position transform
// Angles to unit vector, fixed 3x3 rotation, vector back to angles.
// ============================================================================
// Pipeline: 102 stages, then the output register; each CORDIC and
//   square-root step is a stage.
// Throughput: one item per cycle; a stall freezes the whole pipeline, and a
//   skid register keeps input ready registered.
// Reset: synchronous, active low; clears the valid bits, the output and skid
//   valid flags and the direction register. No clearing pass.
`default_nettype none

module celestial_frame_rotation_top (
  input  logic        clk,
  input  logic        rst_n,
  cfr_in_if.sink      in_item,
  cfr_out_if.source   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NST = cfr_pkg::NST;
  localparam int QW  = cfr_pkg::Q_W;
  localparam int SS  = cfr_pkg::SQRT_STEPS;
  localparam int SW  = cfr_pkg::SQ_W;
  // stage indexes along the valid chain
  localparam int P_TRIG = cfr_pkg::TRIG_LAT - 1;
  localparam int P_SUM  = P_TRIG + cfr_pkg::MID_LAT;
  localparam int P_VEC  = P_SUM + SS + cfr_pkg::VEC_LAT;

  // --------------------------------------------------------------------------
  // configuration: one direction bit
  // --------------------------------------------------------------------------
  logic dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == cfr_pkg::REG_DIRECTION)) begin
      dir_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cfr_pkg::REG_DIRECTION) ? {31'd0, dir_r} : 32'd0;

  // --------------------------------------------------------------------------
  // global advance: the pipeline moves whenever the skid slot is free
  // --------------------------------------------------------------------------
  logic pipe_en;
  logic s_v_r, o_v_r;
  logic o_take;

  assign pipe_en       = !s_v_r;
  assign in_item.ready = pipe_en;
  assign o_take        = o_v_r && out_item.ready;

  logic vld_r  [0:NST-1];
  logic last_r [0:NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) vld_r[k] <= 1'b0;
    end else if (pipe_en) begin
      vld_r[0] <= in_item.valid;
      for (int k = 1; k < NST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      last_r[0] <= in_item.last_sample;
      for (int k = 1; k < NST; k++) last_r[k] <= last_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // sine and cosine of both input angles
  // --------------------------------------------------------------------------
  logic signed [QW-1:0] clon, slon, clat, slat;

  cfr_trig u_trig_lon (
    .clk   (clk),
    .en    (pipe_en),
    .ang_i (in_item.lon_angle),
    .cos_o (clon),
    .sin_o (slon)
  );

  cfr_trig u_trig_lat (
    .clk   (clk),
    .en    (pipe_en),
    .ang_i (in_item.lat_angle),
    .cos_o (clat),
    .sin_o (slat)
  );

  // --------------------------------------------------------------------------
  // unit vector: cos lat cos lon, cos lat sin lon, sin lat
  // --------------------------------------------------------------------------
  logic signed [2*QW-1:0] p0_r, p1_r;
  logic signed [QW-1:0]   pz_r;
  logic signed [QW-1:0]   v_r [3];
  logic signed [2*QW-1:0] t0, t1;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p0_r <= clon * clat;
      p1_r <= slon * clat;
      pz_r <= slat;
    end
  end

  // Q30 round: floor((p + 2^29) / 2^30)
  always_comb begin
    t0 = p0_r + 64'sd536870912;
    t1 = p1_r + 64'sd536870912;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      v_r[0] <= t0[QW+29:30];
      v_r[1] <= t1[QW+29:30];
      v_r[2] <= pz_r;
    end
  end

  // --------------------------------------------------------------------------
  // rotation: nine products, then three rounded sums
  // --------------------------------------------------------------------------
  logic signed [2*QW-1:0] mp_r [3][3];
  logic signed [QW-1:0]   w_r  [3];

  for (genvar i = 0; i < 3; i++) begin : g_row
    logic signed [2*QW+1:0] acc;
    for (genvar j = 0; j < 3; j++) begin : g_col
      logic signed [QW-1:0] m;
      // transposed matrix for galactic to equatorial
      assign m = dir_r ? cfr_pkg::ROT_Q30[j][i] : cfr_pkg::ROT_Q30[i][j];
      always_ff @(posedge clk) begin
        if (pipe_en) mp_r[i][j] <= m * v_r[j];
      end
    end
    always_comb begin
      acc = (2*QW+2)'(mp_r[i][0]) + (2*QW+2)'(mp_r[i][1]) + (2*QW+2)'(mp_r[i][2])
          + 66'sd536870912;
    end
    always_ff @(posedge clk) begin
      if (pipe_en) w_r[i] <= acc[QW+29:30];
    end
  end

  // --------------------------------------------------------------------------
  // planar radius: squares, sum, then one root bit per stage
  // --------------------------------------------------------------------------
  logic [SW-1:0]        sq0_r, sq1_r, rad_r;
  logic signed [QW-1:0] wq_r [3];
  logic signed [QW-1:0] ws_r [3];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq0_r <= w_r[0] * w_r[0];
      sq1_r <= w_r[1] * w_r[1];
      wq_r  <= w_r;
      rad_r <= sq0_r + sq1_r;
      ws_r  <= wq_r;
    end
  end

  logic [SW-1:0]        rem_r [0:SS];
  logic [SW-1:0]        res_r [0:SS];
  logic signed [QW-1:0] sw_r  [0:SS][3];

  always_comb begin
    rem_r[0] = rad_r;
    res_r[0] = '0;
    sw_r[0]  = ws_r;
  end

  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2*k);
    logic [SW-1:0] trial;
    assign trial = res_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        if (rem_r[k] >= trial) begin
          rem_r[k+1] <= rem_r[k] - trial;
          res_r[k+1] <= (res_r[k] >> 1) + BIT;
        end else begin
          rem_r[k+1] <= rem_r[k];
          res_r[k+1] <= res_r[k] >> 1;
        end
        sw_r[k+1] <= sw_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // back to angles: longitude from (x, y), latitude from (r, z)
  // --------------------------------------------------------------------------
  logic [QW-1:0]                      rad;
  logic signed [cfr_pkg::VIN_W-1:0]   vx, vy, vr, vz;
  logic [cfr_pkg::ANGLE_W-1:0]        lon_a, lat_a;
  cfr_pkg::cfr_flags_t                fl_nxt;
  cfr_pkg::cfr_flags_t                fl_r [0:cfr_pkg::VEC_LAT-1];

  always_comb begin
    rad          = res_r[SS][QW-1:0];
    vx           = cfr_pkg::VIN_W'(sw_r[SS][0]);
    vy           = cfr_pkg::VIN_W'(sw_r[SS][1]);
    vz           = cfr_pkg::VIN_W'(sw_r[SS][2]);
    vr           = $signed({1'b0, rad});
    fl_nxt.rz    = (rad == '0);
    fl_nxt.wneg  = sw_r[SS][2][QW-1];
    fl_nxt.wzero = (sw_r[SS][2] == '0);
  end

  cfr_vector u_vec_lon (
    .clk   (clk),
    .en    (pipe_en),
    .x_i   (vx),
    .y_i   (vy),
    .ang_o (lon_a)
  );

  cfr_vector u_vec_lat (
    .clk   (clk),
    .en    (pipe_en),
    .x_i   (vr),
    .y_i   (vz),
    .ang_o (lat_a)
  );

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      fl_r[0] <= fl_nxt;
      for (int k = 1; k < cfr_pkg::VEC_LAT; k++) fl_r[k] <= fl_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // final stage: pole and zero-latitude cases, latitude clamp
  // --------------------------------------------------------------------------
  cfr_pkg::cfr_flags_t        fl;
  logic signed [QW-1:0]       lat_s, lat_f;
  logic [QW-1:0]              lon_f;
  cfr_pkg::cfr_res_t          fin_r;

  always_comb begin
    fl    = fl_r[cfr_pkg::VEC_LAT-1];
    lat_s = $signed(lat_a);
    lon_f = fl.rz ? '0 : lon_a;
    if (fl.wzero) begin
      lat_f = '0;
    end else if (fl.rz) begin
      lat_f = fl.wneg ? -cfr_pkg::QUARTER : cfr_pkg::QUARTER;
    end else if (lat_s > cfr_pkg::QUARTER) begin
      lat_f = cfr_pkg::QUARTER;
    end else if (lat_s < -cfr_pkg::QUARTER) begin
      lat_f = -cfr_pkg::QUARTER;
    end else begin
      lat_f = lat_s;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      fin_r.lon  <= lon_f;
      fin_r.lat  <= lat_f;
      fin_r.last <= last_r[P_VEC];
    end
  end

  // --------------------------------------------------------------------------
  // output register with skid slot
  // --------------------------------------------------------------------------
  logic              ex_v;
  cfr_pkg::cfr_res_t ex_d, o_r, s_r;

  assign ex_v = vld_r[NST-1] && pipe_en;
  always_comb begin
    ex_d      = fin_r;
    ex_d.last = last_r[NST-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else if (s_v_r) begin
      if (o_take) s_v_r <= 1'b0;
    end else if (ex_v) begin
      if (!o_v_r || o_take) o_v_r <= 1'b1;
      else s_v_r <= 1'b1;
    end else if (o_take) begin
      o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_v_r) begin
      if (o_take) o_r <= s_r;
    end else if (ex_v) begin
      if (!o_v_r || o_take) o_r <= ex_d;
      else s_r <= ex_d;
    end
  end

  assign out_item.valid    = o_v_r;
  assign out_item.out_lon  = o_r.lon;
  assign out_item.out_lat  = o_r.lat;
  assign out_item.last_out = o_r.last;

`ifndef SYNTHESIS
  // skid slot is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    s_v_r |-> o_v_r) else $error("skid full while output empty");

  // skid fills only when an item leaves the pipeline into a stalled output
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s_v_r) |-> $past(vld_r[NST-1] && o_v_r && !out_item.ready))
    else $error("skid filled without a stalled output");

  // latitude never exceeds a quarter turn
  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r |-> (o_r.lat <= cfr_pkg::QUARTER) && (o_r.lat >= -cfr_pkg::QUARTER))
    else $error("latitude out of range");

  // a result at a pole carries zero longitude
  a_pole_lon: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_en && vld_r[NST-2] && fl.rz) |=> (fin_r.lon == '0))
    else $error("pole longitude not zero");
`endif

endmodule

`default_nettype wire

FILE: rtl/cfr_trig.sv
// ============================================================================
// cfr_trig: pipelined rotation-mode CORDIC
// Cosine and sine in Q30 of a binary angle, one iteration per stage.
// ============================================================================
`default_nettype none

module cfr_trig (
  input  logic                              clk,
  input  logic                              en,
  input  logic [cfr_pkg::ANGLE_W-1:0]       ang_i,
  output logic signed [cfr_pkg::Q_W-1:0]    cos_o,
  output logic signed [cfr_pkg::Q_W-1:0]    sin_o
);

  localparam int TW = cfr_pkg::TRIG_W;
  localparam int S  = cfr_pkg::STEPS;

  logic signed [TW-1:0] x_r [0:S];
  logic signed [TW-1:0] y_r [0:S];
  logic signed [TW-1:0] z_r [0:S];
  logic                 neg_r [0:S];

  logic [cfr_pkg::ANGLE_W-1:0] qsum, afold;
  logic                        neg_nxt;
  logic signed [TW-1:0]        xneg, yneg;

  // fold into the right half plane
  always_comb begin
    qsum    = ang_i + cfr_pkg::QTR_TURN;
    neg_nxt = qsum[cfr_pkg::ANGLE_W-1];
    afold   = neg_nxt ? ang_i + cfr_pkg::HALF_TURN : ang_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= cfr_pkg::GAIN_Q30;
      y_r[0]   <= '0;
      z_r[0]   <= $signed(TW'($signed(afold)));
      neg_r[0] <= neg_nxt;
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_iter
    logic signed [TW-1:0] dx, dy, at;
    always_comb begin
      dx = y_r[k] >>> k;
      dy = x_r[k] >>> k;
      at = $signed(TW'(cfr_pkg::atan_step(k)));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[k][TW-1]) begin
          x_r[k+1] <= x_r[k] - dx;
          y_r[k+1] <= y_r[k] + dy;
          z_r[k+1] <= z_r[k] - at;
        end else begin
          x_r[k+1] <= x_r[k] + dx;
          y_r[k+1] <= y_r[k] - dy;
          z_r[k+1] <= z_r[k] + at;
        end
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  always_comb begin
    xneg = -x_r[S];
    yneg = -y_r[S];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= neg_r[S] ? xneg[cfr_pkg::Q_W-1:0] : x_r[S][cfr_pkg::Q_W-1:0];
      sin_o <= neg_r[S] ? yneg[cfr_pkg::Q_W-1:0] : y_r[S][cfr_pkg::Q_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cfr_vector.sv
// ============================================================================
// cfr_vector: pipelined vectoring-mode CORDIC
// Binary angle of the vector (x, y), one iteration per stage.
// ============================================================================
`default_nettype none

module cfr_vector (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [cfr_pkg::VIN_W-1:0] x_i,
  input  logic signed [cfr_pkg::VIN_W-1:0] y_i,
  output logic [cfr_pkg::ANGLE_W-1:0]      ang_o
);

  localparam int VW = cfr_pkg::VEC_W;
  localparam int S  = cfr_pkg::STEPS;

  logic signed [VW-1:0]        x_r [0:S];
  logic signed [VW-1:0]        y_r [0:S];
  logic [cfr_pkg::ANGLE_W-1:0] a_r [0:S];

  logic signed [VW-1:0] xe, ye;

  always_comb begin
    xe = VW'(x_i);
    ye = VW'(y_i);
  end

  // left half plane: rotate by a half turn first
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_i[cfr_pkg::VIN_W-1]) begin
        x_r[0] <= -xe;
        y_r[0] <= -ye;
        a_r[0] <= cfr_pkg::HALF_TURN;
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        a_r[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_iter
    logic signed [VW-1:0] dx, dy;
    logic                 ypos;
    always_comb begin
      dx   = y_r[k] >>> k;
      dy   = x_r[k] >>> k;
      ypos = !y_r[k][VW-1] && (y_r[k] != '0);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (ypos) begin
          x_r[k+1] <= x_r[k] + dx;
          y_r[k+1] <= y_r[k] - dy;
          a_r[k+1] <= a_r[k] + cfr_pkg::atan_step(k);
        end else begin
          x_r[k+1] <= x_r[k] - dx;
          y_r[k+1] <= y_r[k] + dy;
          a_r[k+1] <= a_r[k] - cfr_pkg::atan_step(k);
        end
      end
    end
  end

  assign ang_o = a_r[S];

endmodule

`default_nettype wire
